>>> design/srf_pkg.sv
// ----------------------------------------------------------------------------
// srf_pkg
// Shared types, command bundle and sine table generator for the SRF PLL.
// ----------------------------------------------------------------------------
package srf_pkg;

  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;

  typedef enum logic [1:0] {
    OPA_ALPHA,
    OPA_BETA,
    OPA_Q,
    OPA_FREQ
  } opa_sel_e;

  typedef enum logic [2:0] {
    OPB_COS,
    OPB_SIN,
    OPB_IGAIN,
    OPB_PGAIN,
    OPB_SCALE
  } opb_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  typedef enum logic {
    ROM_SIN,
    ROM_COS
  } rom_sel_e;

  typedef struct packed {
    logic     ld_in;
    rom_sel_e rom_sel;
    logic     ld_sin;
    logic     ld_cos;
    opa_sel_e opa;
    opb_sel_e opb;
    acc_op_e  acc_op;
    logic     ld_d;
    logic     ld_q;
    logic     upd_integ;
    logic     ld_freq;
    logic     upd_phase;
    logic     ld_out;
  } srf_cmd_t;

  typedef struct packed {
    logic [31:0] prop_gain;
    logic [31:0] integral_gain_step;
    logic [31:0] step_scale;
  } srf_cfg_t;

  // floor(a*b / 2^60), low 64 bits
  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Taylor term divisor (2k)(2k+1)
  function automatic logic [63:0] div_series(logic [63:0] t, int k);
    case (k)
      1:       return t / 64'd6;
      2:       return t / 64'd20;
      3:       return t / 64'd42;
      4:       return t / 64'd72;
      5:       return t / 64'd110;
      6:       return t / 64'd156;
      7:       return t / 64'd210;
      8:       return t / 64'd272;
      9:       return t / 64'd342;
      10:      return t / 64'd420;
      11:      return t / 64'd506;
      12:      return t / 64'd600;
      13:      return t / 64'd702;
      default: return t;
    endcase
  endfunction

  // Quarter-wave sine entry i, elaboration time only
  function automatic logic [31:0] sine_entry(int tb, int sb, int i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    logic [63:0] lim;
    x = (HALF_PI_Q60 >> tb) * 64'(i)
      + (((HALF_PI_Q60 & ((64'd1 << tb) - 64'd1)) * 64'(i)) >> tb);
    x2 = mul_q60(x, x);
    term = x;
    sum = x;
    for (int k = 1; k <= 13; k++) begin
      term = div_series(mul_q60(term, x2), k);
      if ((k % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum + (64'd1 << (60 - sb))) >> (61 - sb);
    lim = (64'd1 << (sb - 1)) - 64'd1;
    if (v > lim) begin
      v = lim;
    end
    return v[31:0];
  endfunction

endpackage

>>> design/srf_sine_rom.sv
// ----------------------------------------------------------------------------
// srf_sine_rom
// Quarter-wave sine magnitude table, one registered read per cycle.
// ----------------------------------------------------------------------------
module srf_sine_rom #(
  parameter int TABLE_BITS  = 10,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic [TABLE_BITS:0]    addr_i,
  output logic [SAMPLE_BITS-2:0] data_o
);
  import srf_pkg::*;

  localparam int Depth = (1 << TABLE_BITS) + 1;

  logic [SAMPLE_BITS-2:0] tab [Depth];
  logic [SAMPLE_BITS-2:0] data_q;

  for (genvar g = 0; g < Depth; g++) begin : g_tab
    localparam logic [31:0] Entry = sine_entry(TABLE_BITS, SAMPLE_BITS, g);
    assign tab[g] = Entry[SAMPLE_BITS-2:0];
  end

  always_ff @(posedge clk_i) begin
    data_q <= tab[addr_i];
  end

  assign data_o = data_q;

endmodule

>>> design/srf_ctrl.sv
// ----------------------------------------------------------------------------
// srf_ctrl
// Sequencer: handshakes and per-step datapath commands.
// ----------------------------------------------------------------------------
module srf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output srf_pkg::srf_cmd_t cmd_o
);
  import srf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIN,
    ST_COS,
    ST_P0,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_P4,
    ST_P5,
    ST_L0,
    ST_L1,
    ST_L2,
    ST_L3,
    ST_L4,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_SIN;
          end
        end
        ST_SIN:  state_q <= ST_COS;
        ST_COS:  state_q <= ST_P0;
        ST_P0:   state_q <= ST_P1;
        ST_P1:   state_q <= ST_P2;
        ST_P2:   state_q <= ST_P3;
        ST_P3:   state_q <= ST_P4;
        ST_P4:   state_q <= ST_P5;
        ST_P5:   state_q <= ST_L0;
        ST_L0:   state_q <= ST_L1;
        ST_L1:   state_q <= ST_L2;
        ST_L2:   state_q <= ST_L3;
        ST_L3:   state_q <= ST_L4;
        ST_L4:   state_q <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.ld_in   = in_valid_i;
        cmd_o.rom_sel = ROM_SIN;
      end
      ST_SIN: begin
        cmd_o.ld_sin  = 1'b1;
        cmd_o.rom_sel = ROM_COS;
      end
      ST_COS: cmd_o.ld_cos = 1'b1;
      ST_P0: begin
        cmd_o.opa = OPA_ALPHA;
        cmd_o.opb = OPB_COS;
      end
      ST_P1: begin
        cmd_o.opa    = OPA_BETA;
        cmd_o.opb    = OPB_SIN;
        cmd_o.acc_op = ACC_LOAD;
      end
      ST_P2: begin
        cmd_o.opa    = OPA_BETA;
        cmd_o.opb    = OPB_COS;
        cmd_o.acc_op = ACC_ADD;
      end
      ST_P3: begin
        cmd_o.opa    = OPA_ALPHA;
        cmd_o.opb    = OPB_SIN;
        cmd_o.acc_op = ACC_LOAD;
        cmd_o.ld_d   = 1'b1;
      end
      ST_P4: cmd_o.acc_op = ACC_SUB;
      ST_P5: cmd_o.ld_q = 1'b1;
      ST_L0: begin
        cmd_o.opa = OPA_Q;
        cmd_o.opb = OPB_IGAIN;
      end
      ST_L1: begin
        cmd_o.opa       = OPA_Q;
        cmd_o.opb       = OPB_PGAIN;
        cmd_o.upd_integ = 1'b1;
      end
      ST_L2: cmd_o.ld_freq = 1'b1;
      ST_L3: begin
        cmd_o.opa = OPA_FREQ;
        cmd_o.opb = OPB_SCALE;
      end
      ST_L4:   cmd_o.upd_phase = 1'b1;
      ST_DONE: cmd_o.ld_out = out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

>>> design/srf_datapath.sv
// ----------------------------------------------------------------------------
// srf_datapath
// Park rotation, PI loop filter and phase accumulator on one shared multiplier.
// ----------------------------------------------------------------------------
module srf_datapath #(
  parameter int TABLE_BITS  = 10,
  parameter int SAMPLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srf_pkg::srf_cmd_t  cmd_i,
  input  srf_pkg::srf_cfg_t  cfg_i,
  input  logic signed [15:0] alpha_i,
  input  logic signed [15:0] beta_i,
  output logic [31:0]        phase_o,
  output logic signed [15:0] d_o,
  output logic signed [15:0] q_o,
  output logic signed [31:0] freq_o
);
  import srf_pkg::*;

  localparam int AW = SAMPLE_BITS + 17;
  localparam logic [TABLE_BITS:0] TblN = {1'b1, {TABLE_BITS{1'b0}}};

  logic signed [15:0]          alpha_q, beta_q;
  logic signed [SAMPLE_BITS-1:0] sin_q, cos_q;
  logic [63:0]                 prod_q;
  logic signed [AW-1:0]        acc_q;
  logic signed [15:0]          d_q, q_q;
  logic signed [31:0]          freq_q, integ_q;
  logic [31:0]                 phase_q;
  logic [31:0]                 phase_out_q;
  logic signed [15:0]          d_out_q, q_out_q;
  logic signed [31:0]          freq_out_q;

  logic [1:0]                  quad, cquad, qsel;
  logic [TABLE_BITS-1:0]       tidx;
  logic [TABLE_BITS:0]         rom_addr;
  logic [SAMPLE_BITS-2:0]      rom_data;
  logic signed [SAMPLE_BITS-1:0] mag, trig_val;
  logic                        trig_neg;
  logic signed [32:0]          op_a, op_b;
  logic signed [65:0]          mul_full;
  logic signed [AW-1:0]        prod_park, acc_d, park_sh;
  logic signed [15:0]          park_sat;
  logic signed [33:0]          gain_sh;
  logic signed [34:0]          integ_sum, freq_sum;

  function automatic logic signed [31:0] sat32(logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -35'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // table addressing, cos is sin one quadrant ahead
  assign quad  = phase_q[31:30];
  assign cquad = quad + 2'd1;
  assign tidx  = phase_q[29 -: TABLE_BITS];
  assign qsel  = (cmd_i.rom_sel == ROM_SIN) ? quad : cquad;
  assign rom_addr = qsel[0] ? (TblN - {1'b0, tidx}) : {1'b0, tidx};

  srf_sine_rom #(
    .TABLE_BITS (TABLE_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_rom (
    .clk_i (clk_i),
    .addr_i(rom_addr),
    .data_o(rom_data)
  );

  assign mag      = signed'({1'b0, rom_data});
  assign trig_neg = cmd_i.ld_sin ? quad[1] : cquad[1];
  assign trig_val = trig_neg ? -mag : mag;

  always_comb begin
    case (cmd_i.opa)
      OPA_ALPHA: op_a = 33'(alpha_q);
      OPA_BETA:  op_a = 33'(beta_q);
      OPA_Q:     op_a = 33'(q_q);
      OPA_FREQ:  op_a = 33'(freq_q);
      default:   op_a = '0;
    endcase
    case (cmd_i.opb)
      OPB_COS:   op_b = 33'(cos_q);
      OPB_SIN:   op_b = 33'(sin_q);
      OPB_IGAIN: op_b = signed'({1'b0, cfg_i.integral_gain_step});
      OPB_PGAIN: op_b = signed'({1'b0, cfg_i.prop_gain});
      OPB_SCALE: op_b = signed'({1'b0, cfg_i.step_scale});
      default:   op_b = '0;
    endcase
  end

  assign mul_full  = op_a * op_b;
  assign prod_park = signed'(prod_q[AW-1:0]);

  always_comb begin
    case (cmd_i.acc_op)
      ACC_LOAD: acc_d = prod_park;
      ACC_ADD:  acc_d = acc_q + prod_park;
      ACC_SUB:  acc_d = acc_q - prod_park;
      default:  acc_d = acc_q;
    endcase
  end

  assign park_sh = acc_q >>> (SAMPLE_BITS - 1);

  always_comb begin
    if (!park_sh[AW-1] && (park_sh[AW-2:15] != '0)) begin
      park_sat = 16'sh7FFF;
    end else if (park_sh[AW-1] && (park_sh[AW-2:15] != '1)) begin
      park_sat = 16'sh8000;
    end else begin
      park_sat = park_sh[15:0];
    end
  end

  assign gain_sh   = signed'(prod_q[48:15]);
  assign integ_sum = 35'(integ_q) + 35'(gain_sh);
  assign freq_sum  = 35'(integ_q) + 35'(gain_sh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      phase_q <= '0;
    end else begin
      if (cmd_i.upd_integ) begin
        integ_q <= sat32(integ_sum);
      end
      if (cmd_i.upd_phase) begin
        phase_q <= phase_q + prod_q[47:16];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_full[63:0];
    acc_q  <= acc_d;
    if (cmd_i.ld_in) begin
      alpha_q <= alpha_i;
      beta_q  <= beta_i;
    end
    if (cmd_i.ld_sin) begin
      sin_q <= trig_val;
    end
    if (cmd_i.ld_cos) begin
      cos_q <= trig_val;
    end
    if (cmd_i.ld_d) begin
      d_q <= park_sat;
    end
    if (cmd_i.ld_q) begin
      q_q <= park_sat;
    end
    if (cmd_i.ld_freq) begin
      freq_q <= sat32(freq_sum);
    end
    if (cmd_i.ld_out) begin
      phase_out_q <= phase_q;
      d_out_q     <= d_q;
      q_out_q     <= q_q;
      freq_out_q  <= freq_q;
    end
  end

  assign phase_o = phase_out_q;
  assign d_o     = d_out_q;
  assign q_o     = q_out_q;
  assign freq_o  = freq_out_q;

endmodule

>>> design/srf_pll_phase_tracker.sv
// ----------------------------------------------------------------------------
// srf_pll_phase_tracker
// A request is accepted only in the idle state, so the next one waits until the
// result is in the output register; the shared multiplier takes seven
// products in sequence, plus two sine table reads.
// The next request is taken while an earlier result waits in the output register.
// Reset clears loop integrator and phase accumulator and loads register defaults.
// ----------------------------------------------------------------------------
module srf_pll_phase_tracker #(
  parameter int TABLE_BITS  = 10,
  parameter int SAMPLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] alpha_in_i,
  input  logic signed [15:0] beta_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        phase_out_o,
  output logic signed [15:0] d_out_o,
  output logic signed [15:0] q_out_o,
  output logic signed [31:0] freq_out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import srf_pkg::*;

  localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [1:0] REG_IGAIN_STEP = 2'd1;
  localparam logic [1:0] REG_STEP_SCALE = 2'd2;

  srf_cfg_t cfg_q;
  srf_cmd_t cmd;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain          <= '0;
      cfg_q.integral_gain_step <= '0;
      cfg_q.step_scale         <= 32'd68359;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_PROP_GAIN:  cfg_q.prop_gain          <= pwdata;
        REG_IGAIN_STEP: cfg_q.integral_gain_step <= pwdata;
        REG_STEP_SCALE: cfg_q.step_scale         <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PROP_GAIN:  prdata = cfg_q.prop_gain;
      REG_IGAIN_STEP: prdata = cfg_q.integral_gain_step;
      REG_STEP_SCALE: prdata = cfg_q.step_scale;
      default:        prdata = '0;
    endcase
  end

  srf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  srf_datapath #(
    .TABLE_BITS (TABLE_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .cfg_i  (cfg_q),
    .alpha_i(alpha_in_i),
    .beta_i (beta_in_i),
    .phase_o(phase_out_o),
    .d_o    (d_out_o),
    .q_o    (q_out_o),
    .freq_o (freq_out_o)
  );

endmodule

>>> design/srf_chk.sv
// ----------------------------------------------------------------------------
// srf_chk
// Port-level checks for the SRF PLL, bound to the top level.
// ----------------------------------------------------------------------------
module srf_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] phase_out_o,
  input logic [31:0] freq_out_o,
  input logic        pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(phase_out_o) && $stable(freq_out_o))
    else $error("result changed while stalled");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared right after request");

endmodule

bind srf_pll_phase_tracker srf_chk u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .phase_out_o(phase_out_o),
  .freq_out_o (freq_out_o),
  .pready     (pready)
);
